[rtl/ppfl_pkg.sv]
`default_nettype none

package ppfl_pkg;

  // Pool geometry.
  localparam int PAGE_COUNT = 64;
  localparam int PTR_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int CNT_W      = $clog2(PAGE_COUNT + 1);

  // Field widths fixed by the interface.
  localparam int PAGE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int INUSE_W   = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_REINIT = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NONE_USED = 2'd2,
    ST_NOT_USED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [PAGE_W-1:0] page_index;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0]   granted_page;
    logic [STATUS_W-1:0] status;
    logic [INUSE_W-1:0]  pages_in_use;
  } out_item_t;

  // Requests to the free ring. Pop, push and clear never coincide.
  typedef struct packed {
    logic             pop;
    logic             push;
    logic             clear;
    logic [PTR_W-1:0] push_page;
  } ring_ctl_t;

  // Requests to the used bitmap.
  typedef struct packed {
    logic             set;
    logic             clr;
    logic             clear;
    logic [PTR_W-1:0] idx;
  } umap_ctl_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(PAGE_COUNT - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/ppfl_ring.sv]
`default_nettype none

module ppfl_ring
  import ppfl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ring_ctl_t        ctl,
  output logic [PTR_W-1:0]      head_page
);

  logic [PTR_W-1:0]      mem [PAGE_COUNT];
  logic [PTR_W-1:0]      head_r, head_nxt;
  logic [PTR_W-1:0]      tail_r, tail_nxt;
  logic [PAGE_COUNT-1:0] vld_r, vld_nxt;
  logic [PTR_W-1:0]      q_r;
  logic                  qv_r;

  // An entry never written since reset or reinit holds its own index.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    vld_nxt  = vld_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      vld_nxt  = '0;
    end else begin
      if (ctl.pop) begin
        head_nxt = ptr_inc(head_r);
      end
      if (ctl.push) begin
        tail_nxt        = ptr_inc(tail_r);
        vld_nxt[tail_r] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      vld_r  <= '0;
      qv_r   <= 1'b0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      vld_r  <= vld_nxt;
      qv_r   <= vld_nxt[head_nxt];
    end
  end

  // The read data register always tracks the entry at the next head, so
  // the head page is ready for the following command.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.push_page;
    end
    if (ctl.push && (tail_r == head_nxt)) begin
      q_r <= ctl.push_page;
    end else begin
      q_r <= mem[head_nxt];
    end
  end

  assign head_page = qv_r ? q_r : head_r;

endmodule

`default_nettype wire

[rtl/ppfl_used_map.sv]
`default_nettype none

module ppfl_used_map
  import ppfl_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire umap_ctl_t        ctl,
  input  wire logic [PTR_W-1:0] rd_idx,
  output logic                  rd_bit
);

  logic [PAGE_COUNT-1:0] used_r, used_nxt;

  always_comb begin
    used_nxt = used_r;
    if (ctl.clear) begin
      used_nxt = '0;
    end else if (ctl.set) begin
      used_nxt[ctl.idx] = 1'b1;
    end else if (ctl.clr) begin
      used_nxt[ctl.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign rd_bit = used_r[rd_idx];

endmodule

`default_nettype wire

[rtl/page_pool_free_list_allocator_core.sv]
`default_nettype none

// Channel   Ports                            Payload
// input     in_valid, in_ready, in_data      in_item_t  (cmd, page_index)
// result    out_valid, out_ready, out_data   out_item_t (granted_page, status,
//                                                        pages_in_use)
//
// One command per cycle sustained while out_ready stays high; a result passes
// through the input register, then the result register.
// The free ring's registered read of the next head entry gives each command
// the head page left by the one before. Reset and reinit restore the pool.
// A stalled result holds the result register; an empty input register still
// takes one more command and then input ready drops until out_ready returns.

module page_pool_free_list_allocator_core
  import ppfl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic             s1_vld_r;
  in_item_t         s1_item_r;
  logic             out_free;
  logic             fire;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] head_page;
  logic             used_bit;
  logic             page_in_range;
  ring_ctl_t        ring_ctl;
  umap_ctl_t        umap_ctl;
  out_item_t        res;
  out_item_t        out_data_r;
  logic             out_valid_r;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  assign page_in_range = ({1'b0, s1_item_r.page_index} < (PAGE_W + 1)'(PAGE_COUNT));

  always_comb begin
    cnt_nxt           = cnt_r;
    ring_ctl          = '0;
    umap_ctl          = '0;
    res.granted_page  = '0;
    res.status        = ST_OK;
    ring_ctl.push_page = PTR_W'(s1_item_r.page_index);
    umap_ctl.idx      = PTR_W'(s1_item_r.page_index);
    case (s1_item_r.cmd)
      CMD_ALLOC: begin
        if (cnt_r == CNT_W'(PAGE_COUNT)) begin
          res.status = ST_FULL;
        end else begin
          ring_ctl.pop     = fire;
          umap_ctl.set     = fire;
          umap_ctl.idx     = head_page;
          cnt_nxt          = cnt_r + CNT_W'(1);
          res.granted_page = PAGE_W'(head_page);
        end
      end
      CMD_FREE: begin
        if (cnt_r == '0) begin
          res.status = ST_NONE_USED;
        end else if (!page_in_range || !used_bit) begin
          res.status = ST_NOT_USED;
        end else begin
          ring_ctl.push = fire;
          umap_ctl.clr  = fire;
          cnt_nxt       = cnt_r - CNT_W'(1);
        end
      end
      CMD_REINIT: begin
        ring_ctl.clear = fire;
        umap_ctl.clear = fire;
        cnt_nxt        = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    res.pages_in_use = INUSE_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        cnt_r <= cnt_nxt;
      end
      if (out_free) begin
        out_valid_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  ppfl_ring u_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ring_ctl),
    .head_page (head_page)
  );

  ppfl_used_map u_used_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (umap_ctl),
    .rd_idx (PTR_W'(s1_item_r.page_index)),
    .rd_bit (used_bit)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[tb/ppfl_checker.sv]
module ppfl_checker
  import ppfl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  // Shadow copy of the pool: free ring, its pointers and the busy bitmap.
  logic [PAGE_W-1:0]     free_pages [PAGE_COUNT];
  logic [PTR_W-1:0]      pop_ptr;
  logic [PTR_W-1:0]      push_ptr;
  logic [PAGE_COUNT-1:0] page_busy;
  int unsigned           busy_count;
  out_item_t             expected_results [$];

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(PAGE_COUNT - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic void restore_pool();
    for (int i = 0; i < PAGE_COUNT; i++) begin
      free_pages[i] = PAGE_W'(i);
    end
    pop_ptr    = '0;
    push_ptr   = '0;
    page_busy  = '0;
    busy_count = 0;
  endfunction

  function automatic out_item_t next_pool_result(input in_item_t cmd_in);
    out_item_t         r;
    logic [PAGE_W-1:0] pg;
    r        = '0;
    r.status = ST_OK;
    case (cmd_in.cmd)
      CMD_ALLOC: begin
        if (busy_count >= PAGE_COUNT) begin
          r.status = ST_FULL;
        end else begin
          pg                        = free_pages[pop_ptr];
          pop_ptr                   = ring_advance(pop_ptr);
          page_busy[pg[PTR_W-1:0]]  = 1'b1;
          busy_count++;
          r.granted_page            = pg;
        end
      end
      CMD_FREE: begin
        if (busy_count == 0) begin
          r.status = ST_NONE_USED;
        end else if (int'(cmd_in.page_index) >= PAGE_COUNT ||
                     !page_busy[cmd_in.page_index[PTR_W-1:0]]) begin
          r.status = ST_NOT_USED;
        end else begin
          free_pages[push_ptr]                    = cmd_in.page_index;
          push_ptr                                = ring_advance(push_ptr);
          page_busy[cmd_in.page_index[PTR_W-1:0]] = 1'b0;
          busy_count--;
        end
      end
      CMD_REINIT: restore_pool();
      default: ;
    endcase
    r.pages_in_use = INUSE_W'(busy_count);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      restore_pool();
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer, got %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data !== want) begin
            if (out_data.granted_page !== want.granted_page)
              $display("%0t: granted_page mismatch, expected %0d, got %0d",
                       $time, want.granted_page, out_data.granted_page);
            if (out_data.status !== want.status)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, want.status, out_data.status);
            if (out_data.pages_in_use !== want.pages_in_use)
              $display("%0t: pages_in_use mismatch, expected %0d, got %0d",
                       $time, want.pages_in_use, out_data.pages_in_use);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(next_pool_result(in_data));
      end
    end
    pending <= expected_results.size();
  end

endmodule

[tb/tb.sv]
module tb;
  import ppfl_pkg::*;

  localparam int RUN_ITEMS   = 1850;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      calm      = 1'b0;
  int        fail_count;
  int        pending;
  int        cycles    = 0;
  int        issued    = 0;

  always #5 clk = ~clk;

  page_pool_free_list_allocator_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ppfl_checker pool_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 23);
  end

  // Offers one command and returns at the edge where its transfer happens.
  task automatic issue(input cmd_t c, input logic [PAGE_W-1:0] pg);
    if (!calm) begin
      while ($urandom_range(0, 99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= in_item_t'{cmd: c, page_index: pg};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    issued++;
    calm <= (issued >= 700 && issued < 1000);
  endtask

  initial begin
    int kind;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Frees against an empty pool, then the reserved code, then allocs.
    issue(CMD_FREE, 8'd0);
    issue(CMD_FREE, 8'hFF);
    issue(CMD_RSVD, 8'hAA);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_ALLOC, 8'hFF);
    issue(CMD_ALLOC, 8'h00);
    // Pages that are not in use: clear bit in range, and out of range.
    issue(CMD_FREE, 8'd5);
    issue(CMD_FREE, 8'(PAGE_COUNT));
    issue(CMD_FREE, 8'hFF);
    issue(CMD_FREE, 8'd1);
    issue(CMD_FREE, 8'd1);
    issue(CMD_RSVD, 8'h55);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_REINIT, 8'hFF);
    issue(CMD_FREE, 8'd0);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_FREE, 8'd0);
    issue(CMD_ALLOC, 8'h00);
    issue(CMD_FREE, 8'(PAGE_COUNT - 1));

    // Bursts of allocs push the pool to full and bursts of frees drain it.
    while (issued < RUN_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 5) begin
        issue(CMD_REINIT, PAGE_W'($urandom));
      end else if (kind < 40) begin
        repeat ($urandom_range(1, 70)) issue(CMD_ALLOC, PAGE_W'($urandom));
      end else if (kind < 75) begin
        repeat ($urandom_range(1, 40))
          issue(CMD_FREE, PAGE_W'($urandom_range(0, PAGE_COUNT - 1)));
      end else begin
        repeat ($urandom_range(1, 30))
          issue(cmd_t'($urandom_range(0, 3)), PAGE_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
rtl/ppfl_pkg.sv
rtl/ppfl_ring.sv
rtl/ppfl_used_map.sv
rtl/page_pool_free_list_allocator_core.sv
tb/ppfl_checker.sv
tb/tb.sv
